// File: hdl/gaa_pkg.sv
`default_nettype none

package gaa_pkg;

	// tensor and store geometry
	localparam int RANK        = 4;
	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COORD_W     = 12;
	localparam int DIM_W       = 13;
	localparam int DIM_MAX     = 4096;
	localparam int AXIS_W      = 3;
	localparam int AXIS_SEL_W  = $clog2(RANK);
	localparam int DATA_W      = 64;
	localparam int INDEX_W     = 64;
	localparam int CFG_IDX_W   = 3;

	// width of one multiply-accumulate step of the offset
	localparam int PART_W = (ADDR_W > COORD_W) ? ADDR_W : COORD_W;
	localparam int PROD_W = PART_W + DIM_W + 1;

	// item queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_GATHER = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS    = 3'd0,
		REG_DIM0    = 3'd1,
		REG_DIM1    = 3'd2,
		REG_DIM2    = 3'd3,
		REG_DIM3    = 3'd4,
		REG_IDX_LEN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0]       axis;
		logic [RANK-1:0][DIM_W-1:0]     dim;
		logic [DIM_W-1:0]               idx_len;
	} cfg_t;

	// one classified item as handed from front to back
	typedef struct packed {
		op_t                            op;
		logic [ADDR_W-1:0]              addr;
		logic [DATA_W-1:0]              data;
		logic [RANK-1:0][COORD_W-1:0]   coord;
		logic                           err;
		logic                           last;
	} item_t;

	// dimension registers hold 1..DIM_MAX
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(DIM_MAX)) begin
			r = DIM_W'(DIM_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/gaa_front.sv
`default_nettype none

module gaa_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  gaa_pkg::cfg_t                    cfg,
	input  wire                              start,
	input  wire                              full,
	input  wire                              opcode,
	input  wire [gaa_pkg::ADDR_W-1:0]        load_address,
	input  wire [gaa_pkg::DATA_W-1:0]        load_data,
	input  wire signed [gaa_pkg::INDEX_W-1:0] gather_index,
	output logic                             push,
	output gaa_pkg::item_t                   item
);
	import gaa_pkg::*;

	logic [RANK-1:0][COORD_W-1:0] walk_q;
	logic [RANK-1:0][COORD_W-1:0] walk_d;
	logic [RANK-1:0][DIM_W-1:0]   idim;
	logic [RANK-1:0]              wrap;
	logic [AXIS_SEL_W-1:0]        axis_sel;
	logic [DIM_W-1:0]             dim_ax;
	logic [INDEX_W-1:0]           idx_adj;
	logic                         in_range;
	logic                         carry;
	logic                         last;

	assign push = start && !full;

	// walk over the index tensor: per-axis wrap, carry from the innermost axis
	always_comb begin
		axis_sel = cfg.axis[AXIS_SEL_W-1:0];
		carry    = 1'b1;
		walk_d   = walk_q;
		for (int i = 0; i < RANK; i++) begin
			idim[i] = (AXIS_SEL_W'(i) == axis_sel) ? cfg.idx_len : cfg.dim[i];
			wrap[i] = (DIM_W'(walk_q[i]) + DIM_W'(1)) >= idim[i];
		end
		for (int i = RANK - 1; i >= 0; i--) begin
			if (carry) begin
				walk_d[i] = wrap[i] ? '0 : walk_q[i] + COORD_W'(1);
			end
			carry = carry && wrap[i];
		end
		last = &wrap;
	end

	// index wrap and range check along the axis
	always_comb begin
		dim_ax   = cfg.dim[axis_sel];
		idx_adj  = gather_index[INDEX_W-1] ? $unsigned(gather_index) + INDEX_W'(dim_ax)
		                                   : $unsigned(gather_index);
		in_range = !idx_adj[INDEX_W-1] && (idx_adj < INDEX_W'(dim_ax));
	end

	// classified item
	always_comb begin
		item.op    = op_t'(opcode);
		item.addr  = load_address;
		item.data  = load_data;
		item.coord = walk_q;
		item.coord[axis_sel] = idx_adj[COORD_W-1:0];
		item.err   = (op_t'(opcode) == OP_GATHER) && !in_range;
		item.last  = (op_t'(opcode) == OP_GATHER) && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (push && op_t'(opcode) == OP_GATHER) begin
			walk_q <= walk_d;
		end
	end

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && item.last) |=> (walk_q == '0))
		else $error("walk did not return to origin after last item");

endmodule

`default_nettype wire

// File: hdl/gaa_fifo.sv
`default_nettype none

module gaa_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  gaa_pkg::item_t  wr_item,
	output logic            full,
	output logic            pop,
	output gaa_pkg::item_t  rd_item
);
	import gaa_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// back side drains whenever an item is waiting
	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop     = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("item queue overfilled");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && !pop) |=> $stable(count_q))
		else $error("item queue count moved without traffic");

endmodule

`default_nettype wire

// File: hdl/gaa_back.sv
`default_nettype none

module gaa_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  gaa_pkg::cfg_t              cfg,
	input  wire                        pop,
	input  gaa_pkg::item_t             head,
	output logic                       res_valid,
	output logic [gaa_pkg::DATA_W-1:0] res_value,
	output logic                       res_status,
	output logic                       res_last
);
	import gaa_pkg::*;

	// element store
	logic [DATA_W-1:0] store_q [STORE_DEPTH];

	logic [PROD_W-1:0] mac1, mac2, mac3;

	// stage 1: outer product term
	logic                          valid_s1, err_s1, last_s1, ovf_s1;
	op_t                           op_s1;
	logic [ADDR_W-1:0]             addr_s1, part_s1;
	logic [DATA_W-1:0]             data_s1;
	logic [COORD_W-1:0]            c2_s1, c3_s1;
	// stage 2
	logic                          valid_s2, err_s2, last_s2, ovf_s2;
	op_t                           op_s2;
	logic [ADDR_W-1:0]             addr_s2, part_s2;
	logic [DATA_W-1:0]             data_s2;
	logic [COORD_W-1:0]            c3_s2;
	// stage 3: final offset
	logic                          valid_s3, err_s3, last_s3, ovf_s3;
	op_t                           op_s3;
	logic [ADDR_W-1:0]             addr_s3, part_s3;
	logic [DATA_W-1:0]             data_s3;
	// stage 4: read data and result
	logic                          valid_s4, status_s4, last_s4;
	logic [DATA_W-1:0]             rdata_s4;

	// row-major offset, one multiply-accumulate per stage; once past the
	// store the offset only grows, so an overflow flag is carried on
	assign mac1 = PROD_W'(head.coord[0]) * PROD_W'(cfg.dim[1]) + PROD_W'(head.coord[1]);
	assign mac2 = PROD_W'(part_s1) * PROD_W'(cfg.dim[2]) + PROD_W'(c2_s1);
	assign mac3 = PROD_W'(part_s2) * PROD_W'(cfg.dim[3]) + PROD_W'(c3_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && (op_s3 == OP_GATHER);
		end
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		op_s1   <= head.op;
		err_s1  <= head.err;
		last_s1 <= head.last;
		addr_s1 <= head.addr;
		data_s1 <= head.data;
		c2_s1   <= head.coord[2];
		c3_s1   <= head.coord[3];
		ovf_s1  <= mac1 >= PROD_W'(STORE_DEPTH);
		part_s1 <= mac1[ADDR_W-1:0];

		op_s2   <= op_s1;
		err_s2  <= err_s1;
		last_s2 <= last_s1;
		addr_s2 <= addr_s1;
		data_s2 <= data_s1;
		c3_s2   <= c3_s1;
		ovf_s2  <= ovf_s1 || (mac2 >= PROD_W'(STORE_DEPTH));
		part_s2 <= mac2[ADDR_W-1:0];

		op_s3   <= op_s2;
		err_s3  <= err_s2;
		last_s3 <= last_s2;
		addr_s3 <= addr_s2;
		data_s3 <= data_s2;
		ovf_s3  <= ovf_s2 || (mac3 >= PROD_W'(STORE_DEPTH));
		part_s3 <= mac3[ADDR_W-1:0];

		status_s4 <= err_s3 || ovf_s3;
		last_s4   <= last_s3;
	end

	// store access: a load writes, a gather reads, in item order
	always_ff @(posedge clk) begin
		if (valid_s3 && op_s3 == OP_LOAD) begin
			store_q[addr_s3] <= data_s3;
		end
		if (valid_s3 && op_s3 == OP_GATHER && !err_s3 && !ovf_s3) begin
			rdata_s4 <= store_q[part_s3];
		end
	end

	assign res_valid  = valid_s4;
	assign res_status = status_s4;
	assign res_last   = last_s4;
	assign res_value  = status_s4 ? '0 : rdata_s4;

	a_res_from_gather: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> $past(valid_s3 && op_s3 == OP_GATHER))
		else $error("result without a gather item");

	a_ok_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !status_s4) |-> $past(!err_s3 && !ovf_s3))
		else $error("good status for an offset past the store");

endmodule

`default_nettype wire

// File: hdl/gather_along_axis_core.sv
`default_nettype none

// channel   direction  handshake               payload
// command   in         start & !busy           opcode, load_address, load_data, gather_index
// result    out        strobe, one cycle       value, status, last
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// One item is taken per cycle; the queue drains every cycle, so busy only
// rises if the queue were ever full.
// A gather result reaches the result ports through the queue and then these
// registered steps: first multiply-accumulate on the queue head, two more
// multiply-accumulate stages for the row-major offset, one store read.
// Loads give no result; they write the store in item order with the gathers.
// Reset clears the walk position and sets the configuration to axis 0 and all
// sizes 1; store contents stay undefined until loaded. Results cannot be stalled.

module gather_along_axis_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire                                 opcode,
	input  wire [gaa_pkg::ADDR_W-1:0]           load_address,
	input  wire [gaa_pkg::DATA_W-1:0]           load_data,
	input  wire signed [gaa_pkg::INDEX_W-1:0]   gather_index,
	output logic                                strobe,
	output logic [gaa_pkg::DATA_W-1:0]          value,
	output logic                                status,
	output logic                                last,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [gaa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [gaa_pkg::DIM_W-1:0]            cfg_data
);
	import gaa_pkg::*;

	cfg_t  cfg_q;
	item_t front_item;
	item_t head_item;
	logic  push;
	logic  full;
	logic  pop;

	assign cfg_ready = 1'b1;
	assign busy      = full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis    <= '0;
			cfg_q.dim     <= {RANK{DIM_W'(1)}};
			cfg_q.idx_len <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_AXIS:    cfg_q.axis    <= cfg_data[AXIS_W-1:0];
				REG_DIM0:    cfg_q.dim[0]  <= clamp_dim(cfg_data);
				REG_DIM1:    cfg_q.dim[1]  <= clamp_dim(cfg_data);
				REG_DIM2:    cfg_q.dim[2]  <= clamp_dim(cfg_data);
				REG_DIM3:    cfg_q.dim[3]  <= clamp_dim(cfg_data);
				REG_IDX_LEN: cfg_q.idx_len <= clamp_dim(cfg_data);
				default: begin
				end
			endcase
		end
	end

	gaa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.full         (full),
		.opcode       (opcode),
		.load_address (load_address),
		.load_data    (load_data),
		.gather_index (gather_index),
		.push         (push),
		.item         (front_item)
	);

	gaa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (pop),
		.rd_item (head_item)
	);

	gaa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop        (pop),
		.head       (head_item),
		.res_valid  (strobe),
		.res_value  (value),
		.res_status (status),
		.res_last   (last)
	);

endmodule

`default_nettype wire
